// ===== rtl/overlapping_frame_blocker_assert.svh =====
// ----------------------------------------------------------------------------
// Overlapping frame blocker assertion macros
// Concurrent assertion shorthands used by the control RTL (ofb_ctrl).
// ----------------------------------------------------------------------------
`ifndef OVERLAPPING_FRAME_BLOCKER_ASSERT_SVH
`define OVERLAPPING_FRAME_BLOCKER_ASSERT_SVH

// condition holds at every edge out of reset
`define OFB_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define OFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define OFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ofb_pkg.sv =====
// ----------------------------------------------------------------------------
// Overlapping frame blocker package
// Shared constants, codes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ofb_pkg;

	localparam int RING_DEPTH_DEF  = 1024;
	localparam int WINDOW_MAX_DEF  = 512;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int FRAME_NUM_BITS = 32;
	localparam int CFG_BITS       = 10;
	localparam int CFG_IDX_BITS   = 2;

	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_SHIFT   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FLUSH_ALL     = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_REJECT_ON_GAP = 2'd3;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_GET   = 2'd1,
		OP_FLUSH = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_DONE      = 3'd0,
		STAT_GAP       = 3'd1,
		STAT_OVERFLOW  = 3'd2,
		STAT_NOT_READY = 3'd3,
		STAT_EMPTY     = 3'd4,
		STAT_SAMPLE    = 3'd5,
		STAT_REFUSED   = 3'd6
	} stat_t;

	typedef struct packed {
		stat_t                     status;
		logic                      last;
		logic                      fin;
		logic [FRAME_NUM_BITS-1:0] frame_number;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/ofb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ofb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ofb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Overlapping frame blocker control
// Configuration registers, ring pointers and frame state; decides each
// beat's result and issues the ring write or read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "overlapping_frame_blocker_assert.svh"

module ofb_ctrl #(
	parameter int RING_DEPTH  = ofb_pkg::RING_DEPTH_DEF,
	parameter int WINDOW_MAX  = ofb_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = ofb_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [ofb_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
	input  wire logic [ofb_pkg::CFG_BITS-1:0]        cfg_wdata,
	input  wire logic                                accept,
	input  wire logic [1:0]                          opcode,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample_in,
	input  wire logic                                discontinuous,
	output logic                                     ram_we,
	output logic [$clog2(RING_DEPTH)-1:0]            ram_waddr,
	output logic [SAMPLE_BITS-1:0]                   ram_wdata,
	output logic                                     ram_re,
	output logic [$clog2(RING_DEPTH)-1:0]            ram_raddr,
	output ofb_pkg::res_t                            res
);

	localparam int AW   = $clog2(RING_DEPTH);
	localparam int CW   = $clog2(RING_DEPTH + 1);
	localparam int WW   = $clog2(WINDOW_MAX + 1);
	localparam int NW   = WW + 1;
	localparam int CMPW = (WW > ofb_pkg::CFG_BITS) ? WW : ofb_pkg::CFG_BITS;
	localparam int FNB  = ofb_pkg::FRAME_NUM_BITS;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_GET,
		MODE_FLUSH
	} mode_t;

	logic [ofb_pkg::CFG_BITS-1:0] len_cfg_q;
	logic [ofb_pkg::CFG_BITS-1:0] sh_cfg_q;
	logic                         flush_all_q;
	logic                         reject_q;

	logic [AW-1:0]  base_q,   base_n;
	logic [CW-1:0]  fill_q,   fill_n;
	logic [WW-1:0]  pos_q,    pos_n;
	mode_t          mode_q,   mode_n;
	logic [WW-1:0]  size_q,   size_n;
	logic           final_q,  final_n;
	logic [FNB-1:0] frames_q, frames_n;

	logic [CMPW-1:0] len_x, sh_x;
	logic [WW-1:0]   len_c, sh_c, max_c, lim_c;
	logic [NW-1:0]   need_c;
	logic [CW-1:0]   d_c;
	logic [WW-1:0]   pos_e, size_e, pos_inc;
	mode_t           mode_e;
	logic            final_e;
	logic [FNB-1:0]  frames_e;
	logic            fin_c;
	ofb_pkg::op_t    op;

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW + 1)'(a) + (CW + 1)'(b);
		if (s >= (CW + 1)'(RING_DEPTH)) begin
			s = s - (CW + 1)'(RING_DEPTH);
		end
		return AW'(s);
	endfunction

	assign op = ofb_pkg::op_t'(opcode);

	always_comb begin
		len_x = CMPW'(len_cfg_q);
		sh_x  = CMPW'(sh_cfg_q);
		if (len_x == '0) begin
			len_c = WW'(1);
		end else if (len_x > CMPW'(WINDOW_MAX)) begin
			len_c = WW'(WINDOW_MAX);
		end else begin
			len_c = WW'(len_x);
		end
		if (sh_x == '0) begin
			sh_c = WW'(1);
		end else if (sh_x > CMPW'(WINDOW_MAX)) begin
			sh_c = WW'(WINDOW_MAX);
		end else begin
			sh_c = WW'(sh_x);
		end
		max_c  = (len_c > sh_c) ? len_c : sh_c;
		need_c = {max_c, 1'b0};
		lim_c  = flush_all_q ? sh_c : max_c;
		d_c    = (CW'(sh_c) < fill_q) ? CW'(sh_c) : fill_q;
	end

	always_comb begin
		base_n   = base_q;
		fill_n   = fill_q;
		pos_n    = pos_q;
		mode_n   = mode_q;
		size_n   = size_q;
		final_n  = final_q;
		frames_n = frames_q;
		pos_e    = pos_q;
		size_e   = size_q;
		mode_e   = mode_q;
		final_e  = final_q;
		frames_e = frames_q;
		pos_inc  = '0;
		fin_c    = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		res.status       = ofb_pkg::STAT_DONE;
		res.last         = 1'b0;
		res.fin          = 1'b0;
		res.frame_number = frames_q;

		unique case (op) inside
			ofb_pkg::OP_PUT: begin
				if (reject_q && (fill_q != '0) && discontinuous) begin
					res.status = ofb_pkg::STAT_GAP;
				end else if (fill_q >= CW'(RING_DEPTH)) begin
					res.status = ofb_pkg::STAT_OVERFLOW;
				end else begin
					ram_we = 1'b1;
					fill_n = fill_q + CW'(1);
				end
			end
			ofb_pkg::OP_CLEAR: begin
				base_n   = '0;
				fill_n   = '0;
				pos_n    = '0;
				mode_n   = MODE_NONE;
				size_n   = '0;
				final_n  = 1'b0;
				frames_n = '0;
				res.frame_number = '0;
			end
			ofb_pkg::OP_GET, ofb_pkg::OP_FLUSH: begin
				if (mode_q == MODE_NONE) begin
					if (op == ofb_pkg::OP_GET) begin
						if (fill_q < CW'(need_c)) begin
							res.status = ofb_pkg::STAT_NOT_READY;
						end else begin
							mode_e  = MODE_GET;
							size_e  = len_c;
							final_e = 1'b0;
						end
					end else if (fill_q == '0) begin
						res.status = ofb_pkg::STAT_EMPTY;
					end else if (fill_q >= CW'(need_c)) begin
						res.status = ofb_pkg::STAT_REFUSED;
					end else begin
						mode_e  = MODE_FLUSH;
						final_e = CW'(lim_c) >= fill_q;
						size_e  = (CW'(len_c) < fill_q) ? len_c : WW'(fill_q);
					end
					if (mode_e != MODE_NONE) begin
						pos_e    = '0;
						frames_e = frames_q + FNB'(1);
					end
				end
				res.frame_number = frames_e;
				if (mode_e != MODE_NONE) begin
					ram_re     = 1'b1;
					fin_c      = (mode_e == MODE_FLUSH) && final_e;
					res.status = ofb_pkg::STAT_SAMPLE;
					res.fin    = fin_c;
					pos_inc    = pos_e + WW'(1);
					frames_n   = frames_e;
					if (pos_inc >= size_e) begin
						res.last = 1'b1;
						pos_n    = '0;
						mode_n   = MODE_NONE;
						size_n   = '0;
						final_n  = 1'b0;
						if (fin_c) begin
							base_n   = '0;
							fill_n   = '0;
							frames_n = '0;
						end else begin
							base_n = wrap_add(base_q, d_c);
							fill_n = fill_q - d_c;
						end
					end else begin
						pos_n   = pos_inc;
						mode_n  = mode_e;
						size_n  = size_e;
						final_n = final_e;
					end
				end
			end
		endcase
	end

	assign ram_waddr = wrap_add(base_q, fill_q);
	assign ram_wdata = sample_in;
	assign ram_raddr = wrap_add(base_q, CW'(pos_e));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q   <= ofb_pkg::CFG_BITS'(1);
			sh_cfg_q    <= ofb_pkg::CFG_BITS'(1);
			flush_all_q <= 1'b0;
			reject_q    <= 1'b1;
			base_q      <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			mode_q      <= MODE_NONE;
			size_q      <= '0;
			final_q     <= 1'b0;
			frames_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					ofb_pkg::CFG_FRAME_LENGTH:  len_cfg_q   <= cfg_wdata;
					ofb_pkg::CFG_FRAME_SHIFT:   sh_cfg_q    <= cfg_wdata;
					ofb_pkg::CFG_FLUSH_ALL:     flush_all_q <= cfg_wdata[0];
					ofb_pkg::CFG_REJECT_ON_GAP: reject_q    <= cfg_wdata[0];
				endcase
			end
			if (accept) begin
				base_q   <= base_n;
				fill_q   <= fill_n;
				pos_q    <= pos_n;
				mode_q   <= mode_n;
				size_q   <= size_n;
				final_q  <= final_n;
				frames_q <= frames_n;
			end
		end
	end

	`OFB_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= CW'(RING_DEPTH), "fill over depth")
	`OFB_ASSERT_IMPL(a_frame_fits, clk, arst_n, mode_q != MODE_NONE, (pos_q < size_q) && (CW'(size_q) <= fill_q), "frame outruns fill")
	`OFB_ASSERT_IMPL(a_idle_clean, clk, arst_n, mode_q == MODE_NONE, (pos_q == '0) && (size_q == '0) && !final_q, "stale frame state")
	`OFB_ASSERT_NEXT(a_clear, clk, arst_n, accept && (op == ofb_pkg::OP_CLEAR), (fill_q == '0) && (frames_q == '0) && (mode_q == MODE_NONE), "clear not applied")

endmodule

`default_nettype wire

// ===== rtl/overlapping_frame_blocker.sv =====
// ----------------------------------------------------------------------------
// Overlapping frame blocker
// Buffers samples in a ring RAM and hands them out as overlapping frames.
// ----------------------------------------------------------------------------
// channel  dir  tdata                      tuser                   tlast
// s_*      in   sample_in                  opcode, discontinuous   -
// m_*      out  sample_out, frame_number   status, final_flush     last_of_frame
// cfg_*    in   plain write: cfg_we, cfg_addr, cfg_wdata
//
// One beat per cycle sustained while m_tready holds; an input beat is held in
// stage one, then in the output register. Ring RAM read data is registered;
// pointers live in flops, so a write is always visible to the next read. The
// output register plus one stage take one more beat while a result waits.
// Reset clears control only; no clearing pass, ring undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module overlapping_frame_blocker #(
	parameter int RING_DEPTH  = ofb_pkg::RING_DEPTH_DEF,
	parameter int WINDOW_MAX  = ofb_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = ofb_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [ofb_pkg::CFG_IDX_BITS-1:0]       cfg_addr,
	input  wire logic [ofb_pkg::CFG_BITS-1:0]           cfg_wdata,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // sample_in
	input  wire logic [2:0]                             s_tuser,  // opcode, discontinuous
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	output logic [((SAMPLE_BITS+32+7)/8)*8-1:0]         m_tdata,  // sample_out, frame_number
	output logic [3:0]                                  m_tuser,  // status, final_flush
	output logic                                        m_tlast
);

	localparam int AW     = $clog2(RING_DEPTH);
	localparam int OUT_DW = ((SAMPLE_BITS + ofb_pkg::FRAME_NUM_BITS + 7) / 8) * 8;

	logic                   accept;
	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
	ofb_pkg::res_t          res;

	logic                   v_s1;
	ofb_pkg::res_t          res_s1;
	logic                   adv_s1;

	logic                   out_v_q;
	ofb_pkg::res_t          out_res_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;

	assign adv_s1   = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || !out_v_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	ofb_ctrl #(
		.RING_DEPTH  (RING_DEPTH),
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.accept        (accept),
		.opcode        (s_tuser[1:0]),
		.sample_in     (s_tdata[SAMPLE_BITS-1:0]),
		.discontinuous (s_tuser[2]),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.res           (res)
	);

	ofb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we && accept),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re && accept),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
		if (adv_s1) begin
			out_res_q    <= res_s1;
			out_sample_q <= (res_s1.status == ofb_pkg::STAT_SAMPLE) ? ram_rdata : '0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_DW'({out_res_q.frame_number, out_sample_q});
	assign m_tuser  = {out_res_q.fin, out_res_q.status};
	assign m_tlast  = out_res_q.last;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Overlapping frame blocker testbench
// Streams put, get, flush and clear beats through the blocker under random
// idling on both sides and one long output stall. A scoreboard predicts every
// result beat from its own copy of the ring and frame state and checks each
// output beat field by field. The run covers several register settings,
// including a saturated length, and a full ring with overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import ofb_pkg::*;

	localparam int RUN_LIMIT = 400000;

	typedef enum logic [1:0] {
		FRAME_IDLE  = 2'd0,
		FRAME_GET   = 2'd1,
		FRAME_FLUSH = 2'd2
	} frame_mode_t;

	typedef struct {
		stat_t       status;
		logic [15:0] smp;
		logic        last;
		logic        fin;
		logic [31:0] num;
	} frame_result_t;

	class frame_scoreboard;
		logic [9:0]    len_reg;
		logic [9:0]    shift_reg;
		logic          flush_all;
		logic          reject_gap;
		logic [15:0]   ring [RING_DEPTH_DEF];
		int unsigned   base;
		int unsigned   fill;
		int unsigned   pos;
		int unsigned   size_lat;
		frame_mode_t   mode;
		logic          fin_lat;
		logic [31:0]   started;
		frame_result_t due_outputs [$];
		int            errors;

		static function int unsigned window_of(logic [9:0] v);
			if (v == 0) return 1;
			if (v > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
			return v;
		endfunction

		function void empty_ring();
			base = 0;
			fill = 0;
			pos = 0;
			mode = FRAME_IDLE;
			size_lat = 0;
			fin_lat = 0;
		endfunction

		function void reset_state();
			foreach (ring[i]) ring[i] = '0;
			empty_ring();
			started = 0;
			len_reg = 10'd1;
			shift_reg = 10'd1;
			flush_all = 1'b0;
			reject_gap = 1'b1;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
			case (idx)
				CFG_FRAME_LENGTH:  len_reg = val;
				CFG_FRAME_SHIFT:   shift_reg = val;
				CFG_FLUSH_ALL:     flush_all = val[0];
				CFG_REJECT_ON_GAP: reject_gap = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_outputs.size();
		endfunction

		function void predict_output(op_t op, logic [15:0] smp, logic disc);
			int unsigned len, sh, need, lim, d;
			frame_result_t r;
			bit wipe;
			len = window_of(len_reg);
			sh = window_of(shift_reg);
			need = 2 * (len > sh ? len : sh);
			r.status = STAT_DONE;
			r.smp = '0;
			r.last = 1'b0;
			r.fin = 1'b0;
			wipe = 0;
			case (op)
				OP_PUT: begin
					if (reject_gap && fill > 0 && disc) begin
						r.status = STAT_GAP;
					end else if (fill >= RING_DEPTH_DEF) begin
						r.status = STAT_OVERFLOW;
					end else begin
						ring[(base + fill) % RING_DEPTH_DEF] = smp;
						fill++;
					end
				end
				OP_CLEAR: begin
					empty_ring();
					started = 0;
				end
				default: begin
					if (mode == FRAME_IDLE) begin
						if (op == OP_GET) begin
							if (fill < need) begin
								r.status = STAT_NOT_READY;
							end else begin
								mode = FRAME_GET;
								size_lat = len;
								fin_lat = 1'b0;
							end
						end else if (fill == 0) begin
							r.status = STAT_EMPTY;
						end else if (fill >= need) begin
							r.status = STAT_REFUSED;
						end else begin
							lim = flush_all ? sh : need / 2;
							mode = FRAME_FLUSH;
							fin_lat = (lim >= fill);
							size_lat = (len < fill) ? len : fill;
						end
						if (mode != FRAME_IDLE) begin
							pos = 0;
							started++;
						end
					end
					if (mode != FRAME_IDLE) begin
						r.status = STAT_SAMPLE;
						r.smp = ring[(base + pos) % RING_DEPTH_DEF];
						r.fin = (mode == FRAME_FLUSH) && fin_lat;
						pos++;
						if (pos >= size_lat) begin
							r.last = 1'b1;
							if (r.fin) begin
								empty_ring();
								wipe = 1;
							end else begin
								d = (sh < fill) ? sh : fill;
								base = (base + d) % RING_DEPTH_DEF;
								fill -= d;
								pos = 0;
								mode = FRAME_IDLE;
								size_lat = 0;
								fin_lat = 1'b0;
							end
						end
					end
				end
			endcase
			r.num = started;
			if (wipe) started = 0;
			due_outputs.push_back(r);
		endfunction

		task flag_mismatch(string msg);
			if (errors < 100) $display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_output(logic [47:0] data, logic [3:0] user, logic last);
			frame_result_t w;
			if (due_outputs.size() == 0) begin
				flag_mismatch("output beat with nothing expected");
				return;
			end
			w = due_outputs.pop_front();
			if (user[2:0] !== w.status)
				flag_mismatch($sformatf("status got %0d want %0d", user[2:0], w.status));
			if (data[15:0] !== w.smp)
				flag_mismatch($sformatf("sample got %h want %h", data[15:0], w.smp));
			if (last !== w.last)
				flag_mismatch($sformatf("last_of_frame got %b want %b", last, w.last));
			if (user[3] !== w.fin)
				flag_mismatch($sformatf("final_flush got %b want %b", user[3], w.fin));
			if (data[47:16] !== w.num)
				flag_mismatch($sformatf("frame_number got %0d want %0d", data[47:16], w.num));
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_addr;
	logic [CFG_BITS-1:0]     cfg_wdata;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [15:0]             s_tdata;  // sample_in
	logic [2:0]              s_tuser;  // opcode, discontinuous
	logic                    m_tvalid;
	logic                    m_tready;
	logic [47:0]             m_tdata;  // sample_out, frame_number
	logic [3:0]              m_tuser;  // status, final_flush
	logic                    m_tlast;

	frame_scoreboard sb;
	bit              tx_burst;
	int              cycles;

	overlapping_frame_blocker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task send_item(op_t op, logic [15:0] smp, logic disc);
		int unsigned gap;
		if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= {disc, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.predict_output(op, smp, disc);
	endtask

	task send_noise();
		send_item(op_t'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
	endtask

	task settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task program_blocker(logic [9:0] len_w, logic [9:0] sh_w, logic fa, logic rog);
		logic [CFG_IDX_BITS-1:0] addrs [4];
		logic [CFG_BITS-1:0]     vals [4];
		addrs[0] = CFG_FRAME_LENGTH;
		addrs[1] = CFG_FRAME_SHIFT;
		addrs[2] = CFG_FLUSH_ALL;
		addrs[3] = CFG_REJECT_ON_GAP;
		vals[0] = len_w;
		vals[1] = sh_w;
		// upper bits of the one-bit registers are don't-care
		vals[2] = {($urandom_range(0, 1) ? 9'($urandom) : 9'd0), fa};
		vals[3] = {($urandom_range(0, 1) ? 9'($urandom) : 9'd0), rog};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= addrs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.write_reg(addrs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task run_phase(logic [9:0] len_w, logic [9:0] sh_w, int budget);
		int unsigned lw, sw, need, n, pick;
		int sent;
		lw = frame_scoreboard::window_of(len_w);
		sw = frame_scoreboard::window_of(sh_w);
		need = 2 * (lw > sw ? lw : sw);
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				n = need + $urandom_range(0, lw);
				repeat (n) send_item(OP_PUT, 16'($urandom), ($urandom_range(0, 15) == 0));
				sent += n;
				n = lw * $urandom_range(1, 3);
				repeat (n) send_item(OP_GET, 16'($urandom), 1'($urandom));
				sent += n;
			end else if (pick < 70) begin
				if ($urandom_range(0, 1)) begin
					send_item(OP_CLEAR, 16'($urandom), 1'($urandom));
					sent++;
				end
				n = $urandom_range(1, need);
				repeat (n) send_item(OP_PUT, 16'($urandom), ($urandom_range(0, 7) == 0));
				sent += n;
				n = $urandom_range(1, 3 * lw);
				repeat (n) send_item(OP_FLUSH, 16'($urandom), 1'($urandom));
				sent += n;
			end else if (pick < 80) begin
				n = $urandom_range(1, 2 * lw);
				repeat (n) send_item(OP_GET, 16'($urandom), 1'($urandom));
				sent += n;
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_noise();
				sent += n;
			end
		end
	endtask

	initial begin : drain_results
		int unsigned gap;
		int unsigned got;
		bit          burst;
		bit          held;
		got = 0;
		burst = 0;
		held = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 49) == 0) burst = !burst;
			gap = burst ? 0 : $urandom_range(0, 5);
			if (!held && got == 200) begin
				gap = 400;
				held = 1;
			end
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			sb.check_output(m_tdata, m_tuser, m_tlast);
			got++;
		end
	end

	initial begin : main
		logic [9:0] len_w;
		logic [9:0] sh_w;
		sb = new();
		sb.reset_state();
		tx_burst = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		m_tready <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: length 1, shift 1, gap rejection on
		send_item(OP_GET, 16'h0000, 1'b0);
		send_item(OP_FLUSH, 16'hFFFF, 1'b1);
		send_item(OP_PUT, 16'h7FFF, 1'b1);
		send_item(OP_PUT, 16'h8000, 1'b1);
		send_item(OP_FLUSH, 16'h0000, 1'b0);
		send_item(OP_PUT, 16'h8000, 1'b0);
		send_item(OP_PUT, 16'h7FFF, 1'b0);
		send_item(OP_PUT, 16'h5555, 1'b0);
		send_item(OP_PUT, 16'hAAAA, 1'b0);
		send_item(OP_FLUSH, 16'h0000, 1'b0);
		repeat (4) send_item(OP_GET, 16'h0000, 1'b0);
		send_item(OP_CLEAR, 16'hFFFF, 1'b1);
		settle();

		for (int p = 0; p < 6; p++) begin
			len_w = ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom_range(1, 12));
			sh_w = ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom_range(1, 16));
			program_blocker(len_w, sh_w, p[0], p[1]);
			run_phase(len_w, sh_w, 30);
			settle();
		end

		// saturated length: a get needs the whole ring filled
		program_blocker(10'h3FF, 10'($urandom_range(0, 1023)), 1'($urandom), 1'b1);
		for (int i = 0; i < 1032; i++)
			send_item(OP_PUT, 16'($urandom), (i < 400 && i % 97 == 50));
		repeat (6) send_item(OP_GET, 16'($urandom), 1'($urandom));
		repeat (2) send_item(OP_FLUSH, 16'($urandom), 1'($urandom));
		send_item(OP_CLEAR, 16'($urandom), 1'($urandom));
		settle();

		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ofb_pkg.sv
rtl/ofb_ram.sv
rtl/ofb_ctrl.sv
rtl/overlapping_frame_blocker.sv
test/tb.sv
